// ----- rtl/sfcd_pkg.sv -----
package sfcd_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] SIGN_BIT   = 16'h8000;
    localparam logic [15:0] MAG_MASK   = 16'h7FFF;
    localparam logic [2:0]  CRC_BYTES  = 3'd6;

    localparam logic [2:0]  IDX_ADDR     = 3'd0;
    localparam logic [2:0]  IDX_HUM_HI   = 3'd2;
    localparam logic [2:0]  IDX_HUM_LO   = 3'd3;
    localparam logic [2:0]  IDX_TEMP_HI  = 3'd4;
    localparam logic [2:0]  IDX_TEMP_LO  = 3'd5;
    localparam logic [2:0]  IDX_CRC_LO   = 3'd6;
    localparam logic [2:0]  IDX_CRC_HI   = 3'd7;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] rx_byte;
    } sfcd_item_t;

    typedef struct packed {
        logic              status;
        logic [15:0]       humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } sfcd_result_t;

    // one byte of CRC-16/MODBUS, bitwise, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/sfcd_in_reg.sv -----
module sfcd_in_reg
    import sfcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  sfcd_item_t s_item,
    output logic       s_ready,
    input  logic       advance,
    output logic       valid,
    output sfcd_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    sfcd_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ----- rtl/sfcd_frame_core.sv -----
module sfcd_frame_core
    import sfcd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  sfcd_item_t   item,
    input  logic         out_free,
    output logic         advance,
    output logic         res_valid,
    output sfcd_result_t result
);

    logic [2:0]  byte_index_reg, byte_index_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] humidity_reg, humidity_next;
    logic [15:0] temperature_reg, temperature_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic [2:0]  idx;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic [15:0] mag;
    logic [15:0] temp_conv;
    logic        produces;

    assign idx      = item.frame_start ? IDX_ADDR : byte_index_reg;
    assign crc_base = item.frame_start ? CRC_INIT : crc_reg;
    assign crc_upd  = crc_byte(crc_base, item.rx_byte);
    assign produces = in_valid && (idx == IDX_CRC_HI);
    assign advance  = in_valid && (!produces || out_free);

    assign rx_crc    = {item.rx_byte, crc_low_reg};
    assign mag       = temperature_reg & MAG_MASK;
    assign temp_conv = ((temperature_reg & SIGN_BIT) != 16'h0000) ? 16'(16'h0000 - mag) : mag;

    always_comb begin
        if (rx_crc == crc_base) begin
            result.status             = STATUS_OK;
            result.temperature_tenths = temp_conv;
            result.humidity_tenths    = humidity_reg;
        end else begin
            result.status             = STATUS_CRC_ERR;
            result.temperature_tenths = 16'sh0000;
            result.humidity_tenths    = 16'h0000;
        end
    end

    assign res_valid = produces && advance;

    always_comb begin
        byte_index_next  = byte_index_reg;
        crc_next         = crc_reg;
        humidity_next    = humidity_reg;
        temperature_next = temperature_reg;
        crc_low_next     = crc_low_reg;
        if (advance) begin
            byte_index_next = idx + 3'd1;
            if (idx < CRC_BYTES) begin
                crc_next = crc_upd;
            end else if (idx == IDX_CRC_HI) begin
                crc_next = CRC_INIT;
            end else begin
                crc_next = crc_base;
            end
            unique case (idx)
                IDX_HUM_HI:  humidity_next    = {item.rx_byte, humidity_reg[7:0]};
                IDX_HUM_LO:  humidity_next    = {humidity_reg[15:8], item.rx_byte};
                IDX_TEMP_HI: temperature_next = {item.rx_byte, temperature_reg[7:0]};
                IDX_TEMP_LO: temperature_next = {temperature_reg[15:8], item.rx_byte};
                IDX_CRC_LO:  crc_low_next     = item.rx_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg  <= 3'd0;
            crc_reg         <= CRC_INIT;
            humidity_reg    <= 16'h0000;
            temperature_reg <= 16'h0000;
            crc_low_reg     <= 8'h00;
        end else begin
            byte_index_reg  <= byte_index_next;
            crc_reg         <= crc_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
            crc_low_reg     <= crc_low_next;
        end
    end

    a_wrap_after_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (byte_index_reg == IDX_ADDR) && (crc_reg == CRC_INIT))
        else $error("frame end did not restart count and crc");

    a_stall_only_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !advance) |-> (produces && !out_free))
        else $error("item held without cause");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(byte_index_reg) && $stable(crc_reg))
        else $error("state moved without an item");

endmodule

// ----- rtl/sfcd_out_reg.sv -----
module sfcd_out_reg
    import sfcd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  sfcd_result_t result_in,
    output logic         out_free,
    output logic         m_valid,
    input  logic         m_ready,
    output sfcd_result_t result_out
);

    logic         valid_reg;
    logic         valid_next;
    sfcd_result_t result_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = result_reg;

endmodule

// ----- rtl/sensor_frame_crc_decoder_unit.sv -----
// Sensor frame decoder: takes the 8-byte response frame of a temperature and
// humidity sensor one byte per item and, after byte 7, gives one result item.
// CRC-16/MODBUS (init 0xFFFF, poly 0xA001 reflected) covers bytes 0..5 and is
// checked against the little-endian CRC in bytes 6,7. On a match m_tuser is 0
// and m_tdata holds temperature (sign-magnitude converted to two's complement)
// and humidity, both in tenths; on a mismatch m_tuser is 1 and m_tdata is 0.
// s_tuser high marks byte 0 and restarts the count and CRC; without it frames
// simply follow back to back. One item per cycle is taken; an accepted item
// passes the input register and then the result register to the output. Only
// the byte that closes a frame can stall, when the result register is full.
module sensor_frame_crc_decoder_unit
    import sfcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] temperature_tenths, [31:16] humidity_tenths
    output logic        m_tuser    // [0] status
);

    sfcd_item_t   s_item;
    sfcd_item_t   in_item;
    logic         in_valid;
    logic         advance;
    logic         out_free;
    logic         res_valid;
    sfcd_result_t core_result;
    sfcd_result_t out_result;

    assign s_item.rx_byte     = s_tdata;
    assign s_item.frame_start = s_tuser;

    sfcd_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_item  (s_item),
        .s_ready (s_tready),
        .advance (advance),
        .valid   (in_valid),
        .item    (in_item)
    );

    sfcd_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .item      (in_item),
        .out_free  (out_free),
        .advance   (advance),
        .res_valid (res_valid),
        .result    (core_result)
    );

    sfcd_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .result_in  (core_result),
        .out_free   (out_free),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result_out (out_result)
    );

    assign m_tdata = {out_result.humidity_tenths, out_result.temperature_tenths};
    assign m_tuser = out_result.status;

    a_error_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_CRC_ERR) |-> (m_tdata == 32'h0000_0000))
        else $error("crc error item carries data");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |-> s_tready)
        else $error("input blocked while input register empty");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("pending result overwritten");

endmodule

// ----- bench/sensor_frame_crc_decoder_unit_tb.sv -----
module sensor_frame_crc_decoder_unit_tb;
    import sfcd_pkg::*;

    localparam int unsigned LONG_HOLD = 80;

    typedef struct {
        logic [7:0]   data;
        logic         start;
        bit           typed;
        sfcd_result_t want;
    } frame_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // decoder state as seen by the testbench
    logic [2:0]  byte_pos    = '0;
    logic [15:0] crc_run     = CRC_INIT;
    logic [15:0] hum_word    = '0;
    logic [15:0] temp_word   = '0;
    logic [7:0]  crc_lo_seen = '0;

    frame_byte_t  byte_plan[$];
    sfcd_result_t frame_results[$];
    bit           row_typed = 1'b0;
    sfcd_result_t row_want  = '0;
    bit           hold_long = 1'b0;
    int unsigned  mismatch_count = 0;
    bit           got_one;
    sfcd_result_t predicted;
    sfcd_result_t want;

    sensor_frame_crc_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bit-serial, LSB first
    function automatic logic [15:0] modbus_crc_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ d[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [15:0] pick_word();
        logic [15:0] corner[4];
        corner = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF};
        if ($urandom_range(3, 0) == 0) return corner[$urandom_range(3, 0)];
        return 16'($urandom);
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic st,
                               output bit done, output sfcd_result_t res);
        logic [15:0] mag;
        done = 1'b0;
        res  = '0;
        if (st) begin
            byte_pos = '0;
            crc_run  = CRC_INIT;
        end
        if (byte_pos < CRC_BYTES) crc_run = modbus_crc_next(crc_run, b);
        case (byte_pos)
            IDX_HUM_HI:  hum_word[15:8]  = b;
            IDX_HUM_LO:  hum_word[7:0]   = b;
            IDX_TEMP_HI: temp_word[15:8] = b;
            IDX_TEMP_LO: temp_word[7:0]  = b;
            IDX_CRC_LO:  crc_lo_seen     = b;
            IDX_CRC_HI: begin
                done = 1'b1;
                if ({b, crc_lo_seen} == crc_run) begin
                    mag = temp_word & MAG_MASK;
                    res.status          = STATUS_OK;
                    res.humidity_tenths = hum_word;
                    res.temperature_tenths = ((temp_word & SIGN_BIT) != 0) ? 16'h0000 - mag : mag;
                end else begin
                    res.status = STATUS_CRC_ERR;
                end
                crc_run = CRC_INIT;
            end
            default: ;
        endcase
        byte_pos = byte_pos + 3'd1;
    endtask

    task automatic check_field(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
        end
    endtask

    task automatic add_byte(input logic [7:0] data, input logic start,
                            input bit typed = 1'b0, input sfcd_result_t w = '0);
        byte_plan.push_back('{data, start, typed, w});
    endtask

    task automatic add_frame(input bit start, input logic [15:0] hum, input logic [15:0] temp,
                             input bit crc_good, input bit typed, input sfcd_result_t w);
        logic [7:0]  body[6];
        logic [15:0] crc;
        body = '{8'($urandom), 8'($urandom), hum[15:8], hum[7:0], temp[15:8], temp[7:0]};
        crc  = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = modbus_crc_next(crc, body[i]);
            add_byte(body[i], start && i == 0);
        end
        if (!crc_good) crc ^= 16'h0001 << $urandom_range(15, 0);
        add_byte(crc[7:0], 1'b0);
        add_byte(crc[15:8], 1'b0, typed, w);
    endtask

    task automatic add_random_frame(input bit force_good);
        int unsigned kind;
        int unsigned n;
        kind = force_good ? 0 : $urandom_range(99, 0);
        if (kind < 85) begin
            add_frame($urandom_range(9, 0) < 7, pick_word(), pick_word(), kind < 70, 1'b0, '0);
        end else if (kind < 93) begin
            // truncated frame, dropped by the next start mark
            n = $urandom_range(7, 1);
            for (int i = 0; i < n; i++) add_byte(8'($urandom), i == 0);
        end else begin
            n = $urandom_range(10, 1);
            for (int i = 0; i < n; i++) add_byte(8'($urandom), $urandom_range(4, 0) == 0);
        end
    endtask

    task automatic send_plan(input bit no_gaps);
        int unsigned gap;
        gap = 0;
        for (int i = 0; i < byte_plan.size(); i++) begin
            s_tvalid  <= 1'b1;
            s_tdata   <= byte_plan[i].data;
            s_tuser   <= byte_plan[i].start;
            row_typed <= byte_plan[i].typed;
            row_want  <= byte_plan[i].want;
            do @(posedge aclk); while (!s_tready);
            gap = no_gaps ? 0 : pick_gap();
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (gap == 0) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        byte_plan.delete();
    endtask

    task automatic drain_results();
        while (frame_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            decode_byte(s_tdata, s_tuser, got_one, predicted);
            if (got_one) frame_results.push_back(row_typed ? row_want : predicted);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result item with none expected: status %b data %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = frame_results.pop_front();
                check_field("status", 16'(want.status), 16'(m_tuser));
                check_field("temperature", want.temperature_tenths, m_tdata[15:0]);
                check_field("humidity", want.humidity_tenths, m_tdata[31:16]);
            end
        end
    end

    initial begin
        int unsigned run;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_long = 1'b0;
            end else begin
                run = pick_gap();
                if (run == 0) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(12, 1)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat (run) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_frame(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                  '{status: STATUS_OK, humidity_tenths: 16'hFFFF, temperature_tenths: 16'sh8001});
        // partial frame cut short by a new start mark
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h55, 1'b0);
        // negative zero
        add_frame(1'b1, 16'h0000, 16'h8000, 1'b1, 1'b1,
                  '{status: STATUS_OK, humidity_tenths: 16'h0000, temperature_tenths: 16'sh0000});
        // back to back, no start mark, corrupted CRC
        add_frame(1'b0, 16'h1234, 16'h7FFF, 1'b0, 1'b1,
                  '{status: STATUS_CRC_ERR, humidity_tenths: 16'h0000, temperature_tenths: 16'sh0000});
        send_plan(1'b0);
        drain_results();

        // receiver stalls while the sender keeps pushing
        hold_long = 1'b1;
        repeat (10) add_random_frame(1'b1);
        send_plan(1'b1);

        while (byte_plan.size() < 300) add_random_frame(1'b0);
        send_plan(1'b0);
        drain_results();

        while (byte_plan.size() < 300) add_random_frame(1'b0);
        send_plan(1'b0);
        drain_results();
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && frame_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
